// ===== sv/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by lkvc_cell and lru_key_value_cache.
package lkvc_pkg;

  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int CapW = 5;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_PUT = 1'b1
  } lkvc_req_e;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } lkvc_entry_t;

  typedef struct packed {
    logic hit_en;
    logic ins_en;
  } lkvc_ctrl_t;

endpackage

// ===== sv/lkvc_cell.sv =====
// One recency-ordered slot of the LRU cache chain: key compare and shift stage.
// Depends on lkvc_pkg.
module lkvc_cell
  import lkvc_pkg::*;
#(
  parameter int IdxW  = 4,
  parameter int Index = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lkvc_ctrl_t      ctrl_i,
  input  logic [IdxW-1:0] lim_i,
  input  logic [KeyW-1:0] key_i,
  input  lkvc_entry_t     prev_i,
  input  logic            en_i,
  output logic            en_o,
  output lkvc_entry_t     entry_o,
  output logic            hit_o
);

  logic            valid_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] value_q;
  logic            mark;

  assign hit_o = valid_q && (key_q == key_i);
  assign mark  = (ctrl_i.hit_en && hit_o) ||
                 (ctrl_i.ins_en && (lim_i == IdxW'(Index)));
  assign en_o  = mark || en_i;

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      key_q   <= prev_i.key;
      value_q <= prev_i.value;
    end
  end

endmodule

// ===== sv/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache built as a chain of cells.
// Depends on lkvc_pkg and lkvc_cell.
//
//   channel   handshake              payload
//   request   start & !busy          req_type_i, key_i, value_i
//   result    done_o (one cycle)     found_o, read_value_o
//   config    cfg_we_i               cfg_wdata_i (capacity)
//
// Each request is registered on acceptance; then all cells compare the key in
// parallel and the chain shifts entries toward the least recently used end in one
// step, and the result is registered for its result beat. A new request is taken
// every cycle, so busy stays low.
// Reset empties the cache and sets capacity to 16. The receiver cannot stall.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type_i,
  input  logic signed [KeyW-1:0] key_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   done_o,
  output logic                   found_o,
  output logic signed [ValW-1:0] read_value_o,
  input  logic                   cfg_we_i,
  input  logic [CapW-1:0]        cfg_wdata_i
);

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LiveW = $clog2(ENTRIES + 1);
  localparam int CmpW = (LiveW > CapW) ? LiveW : CapW;

  logic [CapW-1:0]  capacity_q;
  logic             req_valid_q;
  lkvc_req_e        req_type_q;
  logic [KeyW-1:0]  key_q;
  logic [ValW-1:0]  value_q;
  logic [LiveW-1:0] live_q;
  logic [LiveW-1:0] live_d;
  logic             done_q;
  logic             found_q;
  logic [ValW-1:0]  read_value_q;

  lkvc_entry_t         entries [ENTRIES];
  lkvc_entry_t         prevs   [ENTRIES];
  logic [ENTRIES:0]    en;
  logic [ENTRIES-1:0]  hits;
  lkvc_entry_t         head;
  lkvc_ctrl_t          ctrl;
  logic [IdxW-1:0]     lim;
  logic [ValW-1:0]     hit_value;
  logic                any_hit;
  logic                cap_zero;
  logic [CmpW-1:0]     cap_ext;
  logic [CmpW-1:0]     eff_cap;
  logic                evict;
  logic                is_put;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_type_q <= lkvc_req_e'(req_type_i);
      key_q      <= key_i;
      value_q    <= value_i;
    end
  end

  assign is_put   = (req_type_q == REQ_PUT);
  assign cap_zero = (capacity_q == '0);
  assign cap_ext  = CmpW'(capacity_q);
  assign eff_cap  = (cap_ext > CmpW'(ENTRIES)) ? CmpW'(ENTRIES) : cap_ext;
  assign evict    = (CmpW'(live_q) >= eff_cap);
  assign any_hit  = |hits;

  always_comb begin
    hit_value = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (hits[j]) begin
        hit_value = hit_value | entries[j].value;
      end
    end
  end

  always_comb begin
    ctrl.hit_en = req_valid_q && !cap_zero;
    ctrl.ins_en = req_valid_q && !cap_zero && is_put && !any_hit;
    lim         = evict ? IdxW'(live_q - LiveW'(1)) : IdxW'(live_q);
    head.valid  = 1'b1;
    head.key    = key_q;
    head.value  = is_put ? value_q : hit_value;
    live_d      = live_q;
    if (ctrl.ins_en && !evict) begin
      live_d = live_q + LiveW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else begin
      live_q <= live_d;
    end
  end

  assign en[ENTRIES] = 1'b0;

  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign prevs[j] = head;
    end else begin : g_link
      assign prevs[j] = entries[j-1];
    end

    lkvc_cell #(
      .IdxW  (IdxW),
      .Index (j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .lim_i   (lim),
      .key_i   (key_q),
      .prev_i  (prevs[j]),
      .en_i    (en[j+1]),
      .en_o    (en[j]),
      .entry_o (entries[j]),
      .hit_o   (hits[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      found_q      <= is_put ? any_hit : (any_hit && !cap_zero && en[0]);
      read_value_q <= (!is_put && any_hit && !cap_zero) ? hit_value : '0;
    end
  end

  assign done_o       = done_q;
  assign found_o      = found_q;
  assign read_value_o = read_value_q;

endmodule

// ===== tb/lru_key_value_cache_tb.sv =====
// Self-checking testbench for lru_key_value_cache: directed and random get/put beats
// against an in-bench LRU predictor, with capacity changes between phases.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 16;

  typedef struct {
    logic            is_cfg;
    logic [CapW-1:0] cap;
    lkvc_req_e       kind;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } cache_op_t;

  typedef struct {
    logic            found;
    logic [ValW-1:0] rdata;
  } lookup_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   req_type_i = 1'b0;
  logic signed [KeyW-1:0] key_i = '0;
  logic signed [ValW-1:0] value_i = '0;
  logic                   done_o;
  logic                   found_o;
  logic signed [ValW-1:0] read_value_o;
  logic                   cfg_we_i = 1'b0;
  logic [CapW-1:0]        cfg_wdata_i = '0;

  cache_op_t      pending_ops[$];
  lookup_result_t expected_results[$];
  int             issued = 0;
  int             retired = 0;
  int             errors = 0;
  int             gap_left = 0;
  int             burst_left = 0;

  logic [KeyW-1:0] line_key[ENTRIES];
  logic [ValW-1:0] line_val[ENTRIES];
  logic            line_live[ENTRIES];
  int              line_rank[ENTRIES];
  int              live_count;
  int              cache_cap;

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .found_o     (found_o),
    .read_value_o(read_value_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic void make_most_recent(input int slot);
    int r;
    r = line_rank[slot];
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_live[i] && line_rank[i] < r) line_rank[i]++;
    end
    line_rank[slot] = 0;
  endfunction

  function automatic int evict_oldest();
    int victim;
    victim = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_live[i] && (victim < 0 || line_rank[i] > line_rank[victim])) victim = i;
    end
    if (victim >= 0) begin
      line_live[victim] = 1'b0;
      if (live_count > 0) live_count--;
    end
    return victim;
  endfunction

  function automatic lookup_result_t cache_access(input lkvc_req_e kind,
                                                  input logic [KeyW-1:0] k,
                                                  input logic [ValW-1:0] v);
    lookup_result_t res;
    int slot;
    int lim;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && line_live[i] && line_key[i] == k) slot = i;
    end
    lim = (cache_cap > ENTRIES) ? ENTRIES : cache_cap;
    res.found = 1'b0;
    res.rdata = '0;
    if (kind == REQ_GET) begin
      if (lim != 0 && slot >= 0) begin
        make_most_recent(slot);
        res.found = 1'b1;
        res.rdata = line_val[slot];
      end
    end else begin
      res.found = (slot >= 0);
      if (lim != 0 && slot >= 0) begin
        line_val[slot] = v;
        make_most_recent(slot);
      end else if (lim != 0) begin
        if (live_count >= lim) void'(evict_oldest());
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (!line_live[i]) slot = i;
        end
        if (slot < 0) slot = evict_oldest();
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (line_live[i]) line_rank[i]++;
          end
          line_key[slot]  = k;
          line_val[slot]  = v;
          line_live[slot] = 1'b1;
          line_rank[slot] = 0;
          live_count++;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic            nxt_start;
    logic            nxt_we;
    cache_op_t       op;
    if (!rst_ni) begin
      start       <= 1'b0;
      cfg_we_i    <= 1'b0;
      req_type_i  <= 1'b0;
      key_i       <= '0;
      value_i     <= '0;
      cfg_wdata_i <= '0;
    end else begin
      nxt_start = start;
      nxt_we    = 1'b0;
      if (start && !busy) issued++;
      if (!start || !busy) begin
        nxt_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0) begin
          if (pending_ops[0].is_cfg) begin
            if (issued == retired && !cfg_we_i) begin
              op = pending_ops[0];
              pending_ops.delete(0);
              nxt_we = 1'b1;
              cfg_wdata_i <= op.cap;
            end
          end else begin
            op = pending_ops[0];
            pending_ops.delete(0);
            nxt_start = 1'b1;
            req_type_i <= op.kind;
            key_i      <= op.key;
            value_i    <= op.value;
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
              burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(1, 12);
            end
          end
        end
      end
      start    <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        line_key[i]  = '0;
        line_val[i]  = '0;
        line_live[i] = 1'b0;
        line_rank[i] = 0;
      end
      live_count = 0;
      cache_cap  = int'(CapReset);
      retired <= 0;
    end else begin
      if (cfg_we_i) cache_cap = int'(cfg_wdata_i);
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: found %0b value %h", $time,
                   found_o, read_value_o);
          errors++;
        end else begin
          exp_res = expected_results[0];
          expected_results.delete(0);
          if (found_o !== exp_res.found) begin
            $display("%0t: found mismatch: expected %0b actual %0b", $time, exp_res.found,
                     found_o);
            errors++;
          end
          if (read_value_o !== exp_res.rdata) begin
            $display("%0t: read_value mismatch: expected %h actual %h", $time,
                     exp_res.rdata, read_value_o);
            errors++;
          end
          retired <= retired + 1;
        end
      end
      if (start && !busy) begin
        expected_results.insert(expected_results.size(),
                                cache_access(lkvc_req_e'(req_type_i), key_i, value_i));
      end
    end
  end

  task automatic add_req(input lkvc_req_e kind, input logic [KeyW-1:0] k,
                         input logic [ValW-1:0] v);
    cache_op_t op;
    op.is_cfg = 1'b0;
    op.cap    = '0;
    op.kind   = kind;
    op.key    = k;
    op.value  = v;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic add_cap(input logic [CapW-1:0] c);
    cache_op_t op;
    op.is_cfg = 1'b1;
    op.cap    = c;
    op.kind   = REQ_GET;
    op.key    = '0;
    op.value  = '0;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  initial begin
    logic [KeyW-1:0] key_pool[$];
    logic [KeyW-1:0] k;
    int              caps[$];
    int              lim;
    int              pool_len;

    add_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    add_req(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    add_req(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    add_req(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    add_req(REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    add_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);
    add_req(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(REQ_GET, 32'h1234_5678, 32'hDEAD_BEEF);
    add_req(REQ_PUT, 32'h0000_0000, 32'h5555_5555);
    add_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    add_cap(5'd0);
    add_req(REQ_PUT, 32'h0000_0000, 32'h0000_0001);
    add_req(REQ_PUT, 32'hAAAA_AAAA, 32'h0000_0001);
    add_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    add_cap(5'd2);
    add_req(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    add_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);
    add_req(REQ_PUT, 32'h0000_1111, 32'h0000_2222);
    add_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    add_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    add_cap(5'd1);
    add_req(REQ_PUT, 32'h0BAD_F00D, 32'h1357_9BDF);
    add_req(REQ_PUT, 32'h0000_2222, 32'h2468_ACE0);
    add_req(REQ_GET, 32'h0BAD_F00D, 32'h0000_0000);
    add_req(REQ_GET, 32'h0000_2222, 32'h0000_0000);
    add_cap(5'd31);

    caps = '{16, 0, 1, 2, 3, 5, 8, 15, 17, 31, 4};
    caps[10] = $urandom_range(0, 31);
    foreach (caps[p]) begin
      add_cap(CapW'(caps[p]));
      lim = (caps[p] > ENTRIES) ? ENTRIES : caps[p];
      pool_len = lim + $urandom_range(1, 6);
      while (key_pool.size() > pool_len) key_pool.delete(0);
      while (key_pool.size() < pool_len) key_pool.insert(key_pool.size(), $urandom);
      key_pool[$urandom_range(0, key_pool.size() - 1)] = $urandom;
      repeat (60) begin
        k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                                         : $urandom;
        add_req(($urandom_range(0, 1) != 0) ? REQ_PUT : REQ_GET, k, $urandom);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_ops.size() != 0 || start || cfg_we_i || issued != retired);
    repeat (6) @(posedge clk_i);
    #1;
    if (errors == 0 && expected_results.size() == 0) begin
      $display("lru_key_value_cache_tb OK");
    end else begin
      $display("lru_key_value_cache_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("lru_key_value_cache_tb NOT OK");
    $finish;
  end

endmodule
